FILE: rtl/stream_unique_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stream unique filter
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STREAM_UNIQUE_FILTER_CORE_MACROS_SVH
`define STREAM_UNIQUE_FILTER_CORE_MACROS_SVH

// Property must hold at every rising edge out of reset.
`define SUFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a rising edge out of reset.
`define SUFR_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/sufr_pkg.sv
// ----------------------------------------------------------------------------
// sufr_pkg
// Shared types for the stream unique filter: the token that walks the cell
// chain and the control state encoding.
// ----------------------------------------------------------------------------
package sufr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic              last;
    logic              hit;
    logic              stored;
    logic [ValueW-1:0] value;
  } sufr_token_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } sufr_state_e;

endpackage

FILE: rtl/stream_unique_filter_core.sv
// An accepted transaction walks the cell chain, waits in the result register
// and then moves to the output register that drives out_valid_o. The token
// walks the chain one cell per cycle and only one is in flight: no new input
// is taken until the result moves on, which waits for a free output register.
// Reset (rst_ni low, asynchronous) empties the store and clears all handshakes.
// ----------------------------------------------------------------------------
// stream_unique_filter_core
// First-occurrence duplicate flagging over sets of 32-bit values, with a
// store of DEPTH distinct values held in a chain of compare cells.
// ----------------------------------------------------------------------------
`include "stream_unique_filter_core_macros.svh"

module stream_unique_filter_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sufr_pkg::ValueW-1:0]     value_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sufr_pkg::ValueW-1:0]     value_out_o,
  output logic                            is_new_o,
  output logic [sufr_pkg::CountW-1:0]     unique_count_o,
  output logic                            overflow_o,
  output logic                            last_out_o
);
  import sufr_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sufr_state_e       state_q, state_d;
  sufr_token_t       tok [DEPTH+1];
  logic              in_fire;
  logic              move;
  logic              clear;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_rep;
  logic [CntW+4:0]   cnt_ext;

  logic              res_new_q, res_ovf_q, res_last_q;
  logic [ValueW-1:0] res_value_q;
  logic [CountW-1:0] res_cnt_q;

  logic              out_valid_q;
  logic              out_new_q, out_ovf_q, out_last_q;
  logic [ValueW-1:0] out_value_q;
  logic [CountW-1:0] out_cnt_q;

  // Next state: one transaction at a time walks the chain.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_RUN;
      S_RUN:   if (tok[DEPTH].vld) state_d = S_HOLD;
      S_HOLD:  if (move) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    move       = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_HOLD:  move = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        move       = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Token entering the first cell.
  always_comb begin
    tok[0].vld    = in_fire;
    tok[0].last   = last_i;
    tok[0].hit    = 1'b0;
    tok[0].stored = 1'b0;
    tok[0].value  = value_i;
  end

  // The store: a row of compare cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sufr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  // Running count; the reported figure includes this value, then a set end clears.
  assign cnt_rep = tok[DEPTH].stored ? (cnt_q + CntW'(1)) : cnt_q;
  assign cnt_ext = {5'd0, cnt_rep};
  assign clear   = tok[DEPTH].vld && tok[DEPTH].last;

  always_comb begin
    cnt_d = cnt_q;
    if (tok[DEPTH].vld) begin
      cnt_d = tok[DEPTH].last ? '0 : cnt_rep;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result held at the chain end until the output register is free.
  always_ff @(posedge clk_i) begin
    if (tok[DEPTH].vld) begin
      res_value_q <= tok[DEPTH].value;
      res_new_q   <= !tok[DEPTH].hit;
      res_ovf_q   <= !tok[DEPTH].hit && !tok[DEPTH].stored;
      res_cnt_q   <= cnt_ext[CountW-1:0];
      res_last_q  <= tok[DEPTH].last;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (move) begin
      out_value_q <= res_value_q;
      out_new_q   <= res_new_q;
      out_ovf_q   <= res_ovf_q;
      out_cnt_q   <= res_cnt_q;
      out_last_q  <= res_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_out_o    = out_value_q;
  assign is_new_o       = out_new_q;
  assign unique_count_o = out_cnt_q;
  assign overflow_o     = out_ovf_q;
  assign last_out_o     = out_last_q;

  // Checks on the control logic.
  `SUFR_ASSERT_NEVER(a_tok_only_in_run, tok[DEPTH].vld && (state_q != S_RUN),
                     "token left chain outside RUN")
  `SUFR_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(DEPTH), "unique count above store depth")
  `SUFR_ASSERT_NEVER(a_hit_and_store,
                     tok[DEPTH].vld && tok[DEPTH].hit && tok[DEPTH].stored,
                     "value both matched and stored")
  `SUFR_ASSERT(a_accept_runs, in_fire |=> (state_q == S_RUN),
               "accepted transaction did not start the chain")

endmodule

FILE: rtl/sufr_cell.sv
// ----------------------------------------------------------------------------
// sufr_cell
// One entry of the distinct-value store. Compares the passing token with its
// entry, claims the token's value when empty, and hands the token on.
// ----------------------------------------------------------------------------
module sufr_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  sufr_pkg::sufr_token_t tok_i,
  output sufr_pkg::sufr_token_t tok_o
);
  import sufr_pkg::*;

  logic              valid_q, valid_d;
  logic [ValueW-1:0] value_q;
  sufr_token_t       tok_q, tok_d;
  logic              match;
  logic              claim;

  // Compare with the held entry; an empty cell takes a value nobody matched.
  // Cells fill in order, so every entry ahead of the first empty cell has
  // already been compared by the time the token reaches it.
  assign match = valid_q && (value_q == tok_i.value);
  assign claim = tok_i.vld && !valid_q && !tok_i.hit && !tok_i.stored;

  always_comb begin
    tok_d        = tok_i;
    tok_d.hit    = tok_i.hit || match;
    tok_d.stored = tok_i.stored || claim;
    valid_d      = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (claim) begin
      valid_d = 1'b1;
    end
  end

  // Control state: entry valid flag and the token handed to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Payload: entry value.
  always_ff @(posedge clk_i) begin
    if (claim) begin
      value_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule
